>>> hw/rtl/assert_macros.svh
// Assertion helper macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every rising clock edge outside reset
`define CHK_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication checked outside reset
`define CHK_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

>>> hw/rtl/f2h_pkg.sv
// ----------------------------------------------------------------------------
// f2h_pkg
// Shared types and constants for the binary32 / binary16 converter.
// ----------------------------------------------------------------------------
package f2h_pkg;
  localparam int unsigned WordW = 32;

  typedef enum logic {
    OP_S2H = 1'b0,
    OP_H2S = 1'b1
  } op_t;

  typedef logic [WordW-1:0] word_t;

  localparam logic [7:0]  F32ExpMax = 8'hff;
  localparam logic [15:0] F16Inf    = 16'h7c00;
  localparam logic [15:0] F16QNan   = 16'h0200;
endpackage

>>> hw/rtl/fp32_fp16_converter_core.sv
// ----------------------------------------------------------------------------
// fp32_fp16_converter_core
// Binary32 <-> binary16 converter, one request per cycle.
// ----------------------------------------------------------------------------
// Input channel: in_valid/in_stall with in_op and in_operand_bits. Op s2h
// rounds binary32 to binary16 (nearest even, result zero-extended); op h2s
// widens the low 16 bits exactly to binary32.
// Output channel: out_valid/out_stall with out_result_bits.
// The conversion logic sits between the inputs and the result register; a
// one-entry skid register, loaded from the same logic, refills the result
// register.
// Throughput: one request per cycle while out_stall is low.
// When the receiver stalls, the result holds and the skid absorbs one more
// request; in_stall rises only once both stages are full.
// Reset empties both stages; there is no other state.
module fp32_fp16_converter_core (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  logic           in_op,
  input  f2h_pkg::word_t in_operand_bits,
  output logic           out_valid,
  input  logic           out_stall,
  output f2h_pkg::word_t out_result_bits
);
  import f2h_pkg::*;

  word_t       h2s_res, conv;
  logic [15:0] s2h_res;
  logic        out_v_r, skid_v_r;
  word_t       out_d_r, skid_d_r;
  logic        acc, take;

  f2h_s2h u_s2h (.u_i(in_operand_bits), .h_o(s2h_res));
  f2h_h2s u_h2s (.h_i(in_operand_bits[15:0]), .s_o(h2s_res));

  assign conv     = (op_t'(in_op) == OP_H2S) ? h2s_res : {16'd0, s2h_res};
  assign in_stall = skid_v_r;
  assign acc      = in_valid && !skid_v_r;
  assign take     = out_v_r && !out_stall;

  // output register with skid stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      if (!out_v_r || take) begin
        if (skid_v_r) begin
          out_v_r  <= 1'b1;
          out_d_r  <= skid_d_r;
          skid_v_r <= 1'b0;
        end else begin
          out_v_r <= acc;
          if (acc) out_d_r <= conv;
        end
      end else if (acc) begin
        skid_v_r <= 1'b1;
        skid_d_r <= conv;
      end
    end
  end

  assign out_valid       = out_v_r;
  assign out_result_bits = out_d_r;
endmodule

>>> hw/rtl/f2h_s2h.sv
// ----------------------------------------------------------------------------
// f2h_s2h
// Binary32 to binary16 with round to nearest even, combinational.
// ----------------------------------------------------------------------------
module f2h_s2h (
  input  f2h_pkg::word_t u_i,
  output logic [15:0]    h_o
);
  import f2h_pkg::*;

  logic [15:0] sgn;
  logic [7:0]  e32;
  logic [22:0] m32;
  logic [9:0]  eb;      // e32 - 112, signed 10 bits
  logic [23:0] full;
  logic [3:0]  sh;
  logic [23:0] m;
  logic [23:0] lost;
  logic        rnd, stk;
  logic [15:0] h;
  logic [12:0] low;

  always_comb begin
    sgn  = {u_i[31], 15'd0};
    e32  = u_i[30:23];
    m32  = u_i[22:0];
    eb   = {2'b00, e32} - 10'd112;
    full = {1'b1, m32};
    sh   = 4'd0;
    m    = '0;
    lost = '0;
    rnd  = 1'b0;
    stk  = 1'b0;
    h    = '0;
    low  = m32[12:0];
    if (e32 == F32ExpMax) begin
      h_o = sgn | F16Inf | ((m32 != '0) ? F16QNan : 16'd0);
    end else if (!eb[9] && eb >= 10'd31) begin
      h_o = sgn | F16Inf;
    end else if (eb[9] || eb == 10'd0) begin
      // subnormal range: eb in -10..0 gives shift 1..11
      if ($signed(eb) < -10'sd10) begin
        h_o = sgn;
      end else begin
        sh   = 4'(10'd1 - eb);
        m    = full >> sh;
        lost = full & ((24'd1 << sh) - 24'd1);
        rnd  = m[12];
        stk  = (m[11:0] != '0) || (lost != '0);
        h    = sgn | {5'd0, m[23:13]};
        if (rnd && (stk || h[0])) h = h + 16'd1;
        h_o  = h;
      end
    end else begin
      // normal range; a mantissa carry steps the exponent
      h = sgn | {1'b0, eb[4:0], m32[22:13]};
      if (low > 13'h1000 || (low == 13'h1000 && h[0])) h = h + 16'd1;
      h_o = h;
    end
  end
endmodule

>>> hw/rtl/f2h_h2s.sv
// ----------------------------------------------------------------------------
// f2h_h2s
// Binary16 to binary32, exact; subnormals normalised by leading-zero count.
// ----------------------------------------------------------------------------
module f2h_h2s (
  input  logic [15:0]    h_i,
  output f2h_pkg::word_t s_o
);
  import f2h_pkg::*;

  logic       sg;
  logic [4:0] ex;
  logic [9:0] mant;
  logic [3:0] lz;
  logic [9:0] mn;

  always_comb begin
    sg   = h_i[15];
    ex   = h_i[14:10];
    mant = h_i[9:0];
    // leading-zero count over the ten mantissa bits
    lz = 4'd0;
    for (int i = 0; i < 10; i++) begin
      if (mant[i]) lz = 4'(9 - i);
    end
    mn = 10'(mant << (lz + 4'd1));
    if (ex == 5'd0) begin
      if (mant == '0) s_o = {sg, 31'd0};
      else s_o = {sg, 8'(8'd112 - {4'd0, lz}), mn, 13'd0};
    end else if (ex == 5'h1f) begin
      s_o = {sg, 8'hff, mant, 13'd0};
    end else begin
      s_o = {sg, 8'({3'd0, ex} + 8'd112), mant, 13'd0};
    end
  end
endmodule

>>> hw/rtl/f2h_checker.sv
// ----------------------------------------------------------------------------
// f2h_checker
// Port-level checks on the converter, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module f2h_checker (
  input logic           clk,
  input logic           rst_n,
  input logic           in_valid,
  input logic           in_stall,
  input logic           in_op,
  input f2h_pkg::word_t in_operand_bits,
  input logic           out_valid,
  input logic           out_stall,
  input f2h_pkg::word_t out_result_bits
);
  import f2h_pkg::*;

  `CHK_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall,
            out_valid && $stable(out_result_bits), "result changed under stall")
  `CHK_NEXT(a_lat, clk, rst_n, in_valid && !in_stall, out_valid,
            "accepted request gave no result")
  `CHK_IMPL(a_stall_only_full, clk, rst_n, in_stall, out_valid,
            "input stalled while output empty")
  `CHK_NEXT(a_s2h_hi, clk, rst_n, in_valid && !in_stall && !out_valid && in_op == OP_S2H,
            out_result_bits[31:16] == 16'd0, "half result not zero-extended")
endmodule

bind fp32_fp16_converter_core f2h_checker u_f2h_checker (.*);
